// ----- rtl/i2c_master_transfer_sequencer_unit_macros.svh -----
// Assertion macros for the I2C transfer sequencer.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define I2CMTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("i2cmts: implication check failed");

// Next-cycle implication.
`define I2CMTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("i2cmts: next-cycle check failed");

`else

`define I2CMTS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define I2CMTS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/i2cmts_pkg.sv -----
package i2cmts_pkg;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;
    localparam int ITEM_DATA_W = 34;
    localparam int DEPTH_CMP_W = 9;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_LOAD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_RX_ACK  = 3'd3;
    localparam logic [2:0] ACT_RX_NACK = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;

    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RSTART       = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
    localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
    localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
    localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] status_code;
        logic [7:0] data_byte;
        logic [2:0] load_index;
        logic [3:0] receive_count;
        logic [3:0] send_count;
        logic [6:0] slave_address;
    } item_t;

    typedef struct packed {
        logic [6:0] target_address;
        logic [3:0] send_position;
        logic [3:0] receive_position;
        logic [3:0] send_total;
        logic [3:0] receive_total;
        logic       reading_mode;
    } seq_state_t;

    typedef struct packed {
        logic       rx_valid;
        logic [2:0] received_index;
        logic [7:0] received_byte;
        logic       receive_done;
        logic       send_done;
        logic [7:0] out_byte;
        logic [2:0] action;
    } res_t;

    typedef struct packed {
        logic       en;
        logic [2:0] slot;
        logic [7:0] data;
    } store_wr_t;

endpackage

// ----- rtl/i2cmts_tx_store.sv -----
module i2cmts_tx_store #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic                  aclk,
    input  logic                  we,
    input  i2cmts_pkg::store_wr_t wr,
    input  logic [3:0]            rd_addr,
    output logic [7:0]            rd_data
);
    import i2cmts_pkg::*;

    // only eight slots are reachable by a load
    localparam int STORE_DEPTH = (BUFFER_DEPTH < 8) ? BUFFER_DEPTH : 8;
    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0] store_reg [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (we && wr.en) begin
            store_reg[wr.slot[IDX_W-1:0]] <= wr.data;
        end
    end

    assign rd_data = store_reg[rd_addr[IDX_W-1:0]];

endmodule

// ----- rtl/i2cmts_step.sv -----
module i2cmts_step #(
    parameter int BUFFER_DEPTH = 8
) (
    input  i2cmts_pkg::item_t      item,
    input  i2cmts_pkg::seq_state_t state,
    input  logic [7:0]             store_byte,
    output i2cmts_pkg::seq_state_t state_next,
    output i2cmts_pkg::res_t       res_next,
    output i2cmts_pkg::store_wr_t  wr
);
    import i2cmts_pkg::*;

    localparam logic [DEPTH_CMP_W-1:0] DEPTH_V = DEPTH_CMP_W'(BUFFER_DEPTH);

    logic [3:0] send_clamp;
    logic [3:0] recv_clamp;
    logic [7:0] status;
    logic [4:0] rx_pos2;
    logic [4:0] rx_total;
    logic [3:0] send_pos_inc;

    always_comb begin
        send_clamp = (DEPTH_CMP_W'(item.send_count) > DEPTH_V) ? DEPTH_V[3:0]
                                                                : item.send_count;
        recv_clamp = (DEPTH_CMP_W'(item.receive_count) > DEPTH_V) ? DEPTH_V[3:0]
                                                                   : item.receive_count;
        status       = item.status_code & STATUS_MASK;
        rx_pos2      = {1'b0, state.receive_position} + 5'd2;
        rx_total     = {1'b0, state.receive_total};
        send_pos_inc = state.send_position + 4'd1;

        state_next = state;
        res_next   = '0;
        wr         = '0;

        unique case (item.kind)
            KIND_START: begin
                if (send_clamp != 4'd0 || recv_clamp != 4'd0) begin
                    state_next.send_position    = 4'd0;
                    state_next.receive_position = 4'd0;
                    state_next.send_total       = send_clamp;
                    state_next.receive_total    = recv_clamp;
                    state_next.target_address   = item.slave_address;
                    state_next.reading_mode     = (send_clamp == 4'd0);
                    res_next.action             = ACT_START;
                end
            end
            KIND_LOAD: begin
                wr.en   = (DEPTH_CMP_W'(item.load_index) < DEPTH_V);
                wr.slot = item.load_index;
                wr.data = item.data_byte;
            end
            KIND_STATUS: begin
                case (status) inside
                    ST_START, ST_RSTART: begin
                        res_next.action   = ACT_SEND;
                        res_next.out_byte = {state.target_address, state.reading_mode};
                    end
                    ST_SLA_W_ACK, ST_DATA_TX_ACK: begin
                        if (state.send_position < state.send_total) begin
                            res_next.action          = ACT_SEND;
                            res_next.out_byte        = store_byte;
                            state_next.send_position = send_pos_inc;
                            res_next.send_done       = (send_pos_inc == state.send_total);
                        end else if (state.receive_total == 4'd0) begin
                            res_next.action = ACT_STOP;
                        end else begin
                            res_next.action         = ACT_START;
                            state_next.reading_mode = 1'b1;
                        end
                    end
                    ST_SLA_R_ACK: begin
                        res_next.action = (state.receive_total <= 4'd1) ? ACT_RX_NACK
                                                                        : ACT_RX_ACK;
                    end
                    ST_DATA_RX_ACK: begin
                        if (rx_pos2 <= rx_total) begin
                            res_next.action = (rx_pos2 < rx_total) ? ACT_RX_ACK : ACT_RX_NACK;
                            res_next.rx_valid       = 1'b1;
                            res_next.received_byte  = item.data_byte;
                            res_next.received_index = state.receive_position[2:0];
                            state_next.receive_position = state.receive_position + 4'd1;
                        end
                    end
                    ST_DATA_RX_NACK: begin
                        res_next.action         = ACT_STOP;
                        res_next.rx_valid       = 1'b1;
                        res_next.received_byte  = item.data_byte;
                        res_next.received_index = state.receive_position[2:0];
                        res_next.receive_done   = 1'b1;
                    end
                    ST_SLA_W_NACK, ST_DATA_TX_NACK, ST_SLA_R_NACK: begin
                        res_next.action = ACT_STOP;
                    end
                    default: begin
                        res_next.action = ACT_NONE;
                    end
                endcase
            end
            default: begin
                res_next.action = ACT_NONE;
            end
        endcase
    end

endmodule

// ----- rtl/i2c_master_transfer_sequencer_unit.sv -----
// I2C master sequencer for a write-then-read transfer. Each input beat (start
// request, transmit-byte load, or bus status event) yields exactly one result
// beat with the next bus action, the byte to drive, the done marks and any
// received byte with its index. One beat is taken per clock while no result
// waits for m_tready: an input register feeds a single pass of decode logic
// into a result register that takes the result beat of the held input beat.
// While a result waits for m_tready, one more input beat can be taken into the
// input register; after that s_tready stays low until the result leaves.
// s_tready follows m_tready combinationally.
module i2c_master_transfer_sequencer_unit #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slave_address[6:0], send_count[10:7], receive_count[14:11],
    // load_index[17:15], data_byte[25:18], status_code[33:26], zero pad
    input  logic [i2cmts_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [i2cmts_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // action[2:0], out_byte[10:3], send_done[11], receive_done[12],
    // received_byte[20:13], received_index[23:21]
    output logic [i2cmts_pkg::M_TDATA_W-1:0] m_tdata,
    // rx_valid[0]
    output logic [i2cmts_pkg::M_TUSER_W-1:0] m_tuser
);
    import i2cmts_pkg::*;

    `include "i2c_master_transfer_sequencer_unit_macros.svh"

    logic       in_valid_reg;
    item_t      in_item_reg;
    item_t      in_item;
    logic       out_valid_reg;
    res_t       res_reg;
    res_t       res_next;
    seq_state_t state_reg;
    seq_state_t state_next;
    store_wr_t  wr;
    logic [7:0] store_byte;
    logic       advance;
    logic       s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign in_item  = {s_tuser, s_tdata[ITEM_DATA_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    i2cmts_step #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_step (
        .item      (in_item_reg),
        .state     (state_reg),
        .store_byte(store_byte),
        .state_next(state_next),
        .res_next  (res_next),
        .wr        (wr)
    );

    i2cmts_tx_store #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_store (
        .aclk   (aclk),
        .we     (advance),
        .wr     (wr),
        .rd_addr(state_reg.send_position),
        .rd_data(store_byte)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.received_index, res_reg.received_byte,
                       res_reg.receive_done, res_reg.send_done,
                       res_reg.out_byte, res_reg.action};
    assign m_tuser  = res_reg.rx_valid;

    `I2CMTS_ASSERT_IMP(a_pos_in_range, aclk, aresetn, 1'b1,
        state_reg.send_position <= state_reg.send_total)
    `I2CMTS_ASSERT_IMP(a_rx_action, aclk, aresetn, out_valid_reg && res_reg.rx_valid,
        res_reg.action == ACT_RX_ACK || res_reg.action == ACT_RX_NACK ||
        res_reg.action == ACT_STOP)
    `I2CMTS_ASSERT_IMP(a_rx_done, aclk, aresetn, out_valid_reg && res_reg.receive_done,
        res_reg.rx_valid && res_reg.action == ACT_STOP)
    `I2CMTS_ASSERT_IMP(a_tx_done, aclk, aresetn, out_valid_reg && res_reg.send_done,
        res_reg.action == ACT_SEND)
    `I2CMTS_ASSERT_NXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg)

endmodule
